[rtl/core/srr_pkg.sv]
// srr_pkg: request/response payload types, csr register indexes and
// controller-datapath command/status structs for the silence run remover.
// No dependencies.
package srr_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int LEVEL_W    = 15;
   localparam int LENGTH_W   = 6;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_QUIET_LEVEL    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SILENCE_LENGTH = 1'd1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       end_of_stream;
   } srr_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_sample;
      logic                       last_of_burst;
   } srr_rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic idle;
      logic take;
      logic rd;
      logic emit_run;
      logic emit_loud;
   } srr_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic new_result;
      logic new_flush;
      logic new_loud;
      logic loud;
      logic run_last;
      logic out_free;
   } srr_sts_type;

endpackage

[rtl/core/silence_run_remover.sv]
// silence_run_remover: top level, removes long runs of quiet audio samples.
// Depends on srr_pkg, srr_ctrl and srr_dp.
//
// Usage:
//   req_*  : one request carries a signed sample and an end_of_stream flag;
//            accepted when req_valid is high and req_stall is low.
//   rsp_*  : retained samples in order; last_of_burst marks the final result
//            of a request. Taken when rsp_valid is high and rsp_stall is low.
//   csr_*  : register writes (index 0 quiet_level, 1 silence_length); csr_ready
//            is always high. Write only while no request is in flight.
// Sequencing:
//   a quiet request that causes no result leaves the controller idle, ready
//   to take the next request at once. A loud request with no run to release
//   passes the LOUD state, which loads its result into the output register
//   before the next request is taken. Each released buffered sample needs a
//   buffer read (RUN_RD), then an output load (RUN_OUT); reads are registered.
// Reset clears the run count, the registers (quiet_level 0, silence_length 1)
// and the output valid flag. While the receiver stalls, the output register
// holds its result and release of a run waits; req_stall stays high until
// all results of the current request are loaded.
module silence_run_remover #(
   parameter int MAX_SILENCE_LEN = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  srr_pkg::srr_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output srr_pkg::srr_rsp_type          rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [srr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [srr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import srr_pkg::*;

   srr_cmd_type cmd;
   srr_sts_type sts;

   assign csr_ready = 1'b1;
   assign req_stall = !cmd.idle;

   srr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   srr_dp #(
      .MAX_SILENCE_LEN (MAX_SILENCE_LEN)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

`ifndef SYNTHESIS
   a_emit_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take, cmd.rd, cmd.emit_run, cmd.emit_loud}))
      else $error("more than one datapath command at once");

   a_quiet_no_result: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && !sts.new_result) |=> cmd.idle)
      else $error("quiet request without result did not return to idle");

   a_loud_last: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_loud |=> (rsp_valid && rsp_data.last_of_burst))
      else $error("loud sample not presented as last of burst");

   a_read_then_out: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |=> (!cmd.idle && !cmd.rd))
      else $error("buffer read not followed by output step");
`endif

endmodule

[rtl/core/srr_ram.sv]
// srr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module srr_ram #(
   parameter  int WIDTH = 16,
   parameter  int DEPTH = 32,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AddrW-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AddrW-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/srr_ctrl.sv]
// srr_ctrl: sequencing state machine of the silence run remover.
// Depends on srr_pkg (command/status structs).
module srr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  srr_pkg::srr_sts_type sts,
   output srr_pkg::srr_cmd_type cmd
);
   import srr_pkg::*;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_RUN_RD  = 2'd1;
   localparam logic [1:0] ST_RUN_OUT = 2'd2;
   localparam logic [1:0] ST_LOUD    = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.idle = 1'b1;
            cmd.take = req_valid;
            if (req_valid) begin
               if (sts.new_flush) begin
                  state_in = ST_RUN_RD;
               end else if (sts.new_loud) begin
                  state_in = ST_LOUD;
               end
            end
         end
         ST_RUN_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_RUN_OUT;
         end
         ST_RUN_OUT: begin
            if (sts.out_free) begin
               cmd.emit_run = 1'b1;
               if (!sts.run_last) begin
                  state_in = ST_RUN_RD;
               end else if (sts.loud) begin
                  state_in = ST_LOUD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LOUD: begin
            if (sts.out_free) begin
               cmd.emit_loud = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/srr_dp.sv]
// srr_dp: datapath of the silence run remover: csr registers, quiet test,
// run counter, quiet sample buffer, flush index and output register.
// Depends on srr_pkg and srr_ram.
module srr_dp #(
   parameter int MAX_SILENCE_LEN = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [srr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [srr_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  srr_pkg::srr_req_type                 req_data,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output srr_pkg::srr_rsp_type                 rsp_data,
   input  srr_pkg::srr_cmd_type                 cmd,
   output srr_pkg::srr_sts_type                 sts
);
   import srr_pkg::*;

   localparam int CntW  = $clog2(MAX_SILENCE_LEN + 1);
   localparam int AddrW = (MAX_SILENCE_LEN > 1) ? $clog2(MAX_SILENCE_LEN) : 1;
   localparam logic [LENGTH_W:0] MaxLen = (LENGTH_W + 1)'(MAX_SILENCE_LEN);

   logic [LEVEL_W-1:0]  quiet_level_ff;
   logic [LENGTH_W-1:0] silence_length_ff;
   logic [CntW-1:0]     run_count_ff, run_count_in;
   logic [CntW-1:0]     flush_n_ff;
   logic [CntW-1:0]     idx_ff, idx_in;
   logic                loud_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   srr_rsp_type         rsp_ff, rsp_in;

   logic [CntW-1:0]       eff_len;
   logic signed [SAMPLE_W:0] smp_ext, lvl_pos, lvl_neg;
   logic                  quiet;
   logic                  can_store;
   logic                  result_needed;
   logic [CntW-1:0]       count_after;
   logic [CntW-1:0]       flush_n_in;
   logic [SAMPLE_W-1:0]   ram_q;

   // csr registers, to be written only while idle; the block itself does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         quiet_level_ff    <= '0;
         silence_length_ff <= LENGTH_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_QUIET_LEVEL:    quiet_level_ff    <= csr_wdata[LEVEL_W-1:0];
            CSR_SILENCE_LENGTH: silence_length_ff <= csr_wdata[LENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp length to 1..MAX_SILENCE_LEN
   always_comb begin
      if (silence_length_ff == '0) begin
         eff_len = CntW'(1);
      end else if ({1'b0, silence_length_ff} > MaxLen) begin
         eff_len = CntW'(MAX_SILENCE_LEN);
      end else begin
         eff_len = CntW'(silence_length_ff);
      end
   end

   always_comb begin
      smp_ext       = {req_data.sample[SAMPLE_W-1], req_data.sample};
      lvl_pos       = {2'b00, quiet_level_ff};
      lvl_neg       = -lvl_pos;
      quiet         = (smp_ext >= lvl_neg) && (smp_ext <= lvl_pos);
      can_store     = quiet && (run_count_ff < eff_len);
      count_after   = can_store ? CntW'(run_count_ff + 1'b1) : run_count_ff;
      result_needed = !quiet || req_data.end_of_stream;
      // a run that reached the length is dropped
      flush_n_in    = (count_after < eff_len) ? count_after : '0;
   end

   always_comb begin
      run_count_in = run_count_ff;
      if (cmd.take) begin
         run_count_in = result_needed ? '0 : count_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_count_ff <= '0;
      end else begin
         run_count_ff <= run_count_in;
      end
   end

   srr_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_SILENCE_LEN)
   ) u_buf (
      .clock (clock),
      .we    (cmd.take && can_store),
      .waddr (AddrW'(run_count_ff)),
      .wdata (req_data.sample),
      .re    (cmd.rd),
      .raddr (AddrW'(idx_ff)),
      .rdata (ram_q)
   );

   always_comb begin
      idx_in = idx_ff;
      if (cmd.take) begin
         idx_in = '0;
      end else if (cmd.emit_run) begin
         idx_in = CntW'(idx_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.take) begin
         flush_n_ff <= flush_n_in;
         loud_ff    <= !quiet;
         sample_ff  <= req_data.sample;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (cmd.emit_run) begin
         rsp_valid_in         = 1'b1;
         rsp_in.out_sample    = ram_q;
         rsp_in.last_of_burst = sts.run_last && !loud_ff;
      end else if (cmd.emit_loud) begin
         rsp_valid_in         = 1'b1;
         rsp_in.out_sample    = sample_ff;
         rsp_in.last_of_burst = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      sts            = '0;
      sts.new_result = result_needed;
      sts.new_flush  = result_needed && (flush_n_in != '0);
      sts.new_loud   = !quiet;
      sts.loud       = loud_ff;
      sts.run_last   = (CntW'(idx_ff + 1'b1) == flush_n_ff);
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

endmodule
